// ===== src/hsv_to_rgb_converter_assert.svh =====
// assertion macros for the converter module
`ifndef HSV_TO_RGB_CONVERTER_ASSERT_SVH
`define HSV_TO_RGB_CONVERTER_ASSERT_SVH

// checked outside reset only
`define HSV_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define HSV_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== src/hsv_pkg.sv =====
package hsv_pkg;

    // clamped percentages
    localparam int unsigned PCT_W   = 7;
    localparam int unsigned PCT_MAX = 100;
    // channel coefficients, up to 255*100
    localparam int unsigned COEF_W  = 15;
    localparam int unsigned SECT_W  = 3;
    localparam int unsigned PROD_W  = PCT_W + COEF_W;
    // quotient path: floor(x / 10000) = floor((x >> 4) / 625)
    localparam int unsigned Y_W     = PROD_W - 4;
    localparam int unsigned RECIP_W = 19;
    localparam int unsigned RECIP_SH = 28;

    localparam logic [COEF_W-1:0]  K_FULL_COEF = COEF_W'(25500);
    localparam logic [PROD_W-1:0]  K_ROUND_OFS = PROD_W'(5000);
    localparam logic [RECIP_W-1:0] K_RECIP_625 = RECIP_W'(429497);

    // sector base values of 6*hue, multiples of 255
    localparam logic [10:0] K_SECT_BASE [7] = '{
        11'd0, 11'd255, 11'd510, 11'd765, 11'd1020, 11'd1275, 11'd1530
    };

    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } t_stage_en;

    typedef struct packed {
        logic [PCT_W-1:0]  v;
        logic [COEF_W-1:0] cp;
        logic [COEF_W-1:0] cq;
        logic [COEF_W-1:0] ct;
        logic [SECT_W-1:0] sector;
    } t_coef;

endpackage

// ===== src/hsv_front.sv =====
module hsv_front
    import hsv_pkg::*;
(
    input  logic      i_clk,
    input  t_stage_en i_en,
    input  logic [7:0] i_hue,
    input  logic [7:0] i_saturation,
    input  logic [7:0] i_brightness,
    output t_coef     o_coef
);

    logic [PCT_W-1:0]  n_s1_s;
    logic [PCT_W-1:0]  n_s1_v;
    logic [SECT_W-1:0] n_s1_sector;
    logic [7:0]        n_s1_rem;
    logic [10:0]       scaled;

    logic [PCT_W-1:0]  r_s1_s;
    logic [PCT_W-1:0]  r_s1_v;
    logic [SECT_W-1:0] r_s1_sector;
    logic [7:0]        r_s1_rem;

    logic [COEF_W-1:0] n_s2_cp;
    logic [COEF_W-1:0] n_s2_cq;
    logic [COEF_W-1:0] n_s2_ct;
    t_coef             r_coef;

    // clamp percentages, split 6*hue into sector and remainder
    always_comb begin
        n_s1_s = (i_saturation > 8'(PCT_MAX)) ? PCT_W'(PCT_MAX) : i_saturation[PCT_W-1:0];
        n_s1_v = (i_brightness > 8'(PCT_MAX)) ? PCT_W'(PCT_MAX) : i_brightness[PCT_W-1:0];
        scaled = 11'({3'd0, i_hue} * 11'd6);
        n_s1_sector = '0;
        for (int k = 1; k < 7; k++) begin
            if (scaled >= K_SECT_BASE[k]) begin
                n_s1_sector = SECT_W'(k);
            end
        end
        n_s1_rem = 8'(scaled - K_SECT_BASE[n_s1_sector]);
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s1) begin
            r_s1_s      <= n_s1_s;
            r_s1_v      <= n_s1_v;
            r_s1_sector <= n_s1_sector;
            r_s1_rem    <= n_s1_rem;
        end
    end

    // scaled levels p, q and t before the brightness product
    always_comb begin
        n_s2_cp = COEF_W'((PCT_W'(PCT_MAX) - r_s1_s) * COEF_W'(255));
        n_s2_cq = K_FULL_COEF - COEF_W'(r_s1_s * r_s1_rem);
        n_s2_ct = K_FULL_COEF - COEF_W'(r_s1_s * (8'd255 - r_s1_rem));
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s2) begin
            r_coef.v      <= r_s1_v;
            r_coef.cp     <= n_s2_cp;
            r_coef.cq     <= n_s2_cq;
            r_coef.ct     <= n_s2_ct;
            r_coef.sector <= r_s1_sector;
        end
    end

    assign o_coef = r_coef;

endmodule

// ===== src/hsv_chan.sv =====
module hsv_chan
    import hsv_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [PCT_W-1:0]  i_v,
    input  logic [COEF_W-1:0] i_coef,
    output logic [7:0]        o_level
);

    logic [PROD_W-1:0]          n_sum;
    logic [Y_W-1:0]             r_y;
    logic [Y_W+RECIP_W-1:0]     quot;

    // brightness product with the half step for rounding
    assign n_sum = PROD_W'(i_v * i_coef) + K_ROUND_OFS;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_y <= n_sum[PROD_W-1:4];
        end
    end

    // divide by 625 through the reciprocal
    assign quot    = (Y_W+RECIP_W)'(r_y * K_RECIP_625);
    assign o_level = quot[RECIP_SH+7:RECIP_SH];

endmodule

// ===== src/hsv_to_rgb_converter.sv =====
// HSV to RGB colour converter.
// Input channel: i_valid / o_stall carry one colour per beat, i_hue (0..255 for
// 0..360 degrees), i_saturation and i_brightness in percent, clamped at 100.
// Output channel: o_valid / i_stall carry one beat of o_red, o_green, o_blue.
// A beat is taken at a rising edge where valid is high and stall is low.
// Four register stages lie between an accepted input and the result on the output
// register; one colour per cycle is sustained while the receiver does not stall.
// Stages: clamp and sector split, p/q/t coefficients, brightness product,
// reciprocal division by 625 with channel permutation into the output register.
// Each stage holds a valid bit and moves on when the stage after it is empty
// or moving, so bubbles close up and beats keep flowing while a result waits.
// When the receiver stalls, the output holds and the pipeline fills; o_stall
// rises once all four stages hold beats. No beat is lost or repeated.
// Synchronous active-low reset clears all valid bits; o_valid is low after it.
module hsv_to_rgb_converter
    import hsv_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_hue,
    input  logic [7:0] i_saturation,
    input  logic [7:0] i_brightness,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_red,
    output logic [7:0] o_green,
    output logic [7:0] o_blue
);

`include "hsv_to_rgb_converter_assert.svh"

    logic              r_v1;
    logic              r_v2;
    logic              r_v3;
    logic              r_v4;
    logic              en4;
    t_stage_en         en;
    t_coef             coef;
    logic [SECT_W-1:0] r_sector3;
    logic [7:0]        lvl_v;
    logic [7:0]        lvl_p;
    logic [7:0]        lvl_q;
    logic [7:0]        lvl_t;
    logic [7:0]        n_red;
    logic [7:0]        n_green;
    logic [7:0]        n_blue;
    logic [7:0]        r_red;
    logic [7:0]        r_green;
    logic [7:0]        r_blue;

    // stage enables, a stage moves when empty or when its successor moves
    always_comb begin
        en4   = !r_v4 || !i_stall;
        en.s3 = !r_v3 || en4;
        en.s2 = !r_v2 || en.s3;
        en.s1 = !r_v1 || en.s2;
    end

    assign o_stall = !en.s1;

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (en.s1) r_v1 <= i_valid;
            if (en.s2) r_v2 <= r_v1;
            if (en.s3) r_v3 <= r_v2;
            if (en4)   r_v4 <= r_v3;
        end
    end

    // sector and coefficients
    hsv_front u_front (
        .i_clk        (i_clk),
        .i_en         (en),
        .i_hue        (i_hue),
        .i_saturation (i_saturation),
        .i_brightness (i_brightness),
        .o_coef       (coef)
    );

    // one divider lane per level
    hsv_chan u_chan_v (
        .i_clk   (i_clk),
        .i_en    (en.s3),
        .i_v     (coef.v),
        .i_coef  (K_FULL_COEF),
        .o_level (lvl_v)
    );

    hsv_chan u_chan_p (
        .i_clk   (i_clk),
        .i_en    (en.s3),
        .i_v     (coef.v),
        .i_coef  (coef.cp),
        .o_level (lvl_p)
    );

    hsv_chan u_chan_q (
        .i_clk   (i_clk),
        .i_en    (en.s3),
        .i_v     (coef.v),
        .i_coef  (coef.cq),
        .o_level (lvl_q)
    );

    hsv_chan u_chan_t (
        .i_clk   (i_clk),
        .i_en    (en.s3),
        .i_v     (coef.v),
        .i_coef  (coef.ct),
        .o_level (lvl_t)
    );

    always_ff @(posedge i_clk) begin
        if (en.s3) begin
            r_sector3 <= coef.sector;
        end
    end

    // channel permutation by sector, top sector shares the last case
    always_comb begin
        unique case (r_sector3)
            3'd0: begin
                n_red = lvl_v; n_green = lvl_t; n_blue = lvl_p;
            end
            3'd1: begin
                n_red = lvl_q; n_green = lvl_v; n_blue = lvl_p;
            end
            3'd2: begin
                n_red = lvl_p; n_green = lvl_v; n_blue = lvl_t;
            end
            3'd3: begin
                n_red = lvl_p; n_green = lvl_q; n_blue = lvl_v;
            end
            3'd4: begin
                n_red = lvl_t; n_green = lvl_p; n_blue = lvl_v;
            end
            default: begin
                n_red = lvl_v; n_green = lvl_p; n_blue = lvl_q;
            end
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (en4) begin
            r_red   <= n_red;
            r_green <= n_green;
            r_blue  <= n_blue;
        end
    end

    assign o_valid = r_v4;
    assign o_red   = r_red;
    assign o_green = r_green;
    assign o_blue  = r_blue;

    // assertions
    `HSV_ASSERT(a_stall_full, o_stall |-> (r_v1 && r_v2 && r_v3 && r_v4), "stall with empty stage")
    `HSV_ASSERT(a_accept_lands, (i_valid && !o_stall) |=> r_v1, "accepted beat not in first stage")
    `HSV_ASSERT(a_held_result, (o_valid && i_stall) |=> (o_valid && $stable(o_red)), "held result dropped")
    `HSV_ASSERT_ALWAYS(a_reset_empty, !$past(i_rst_n) |-> !o_valid, "valid output after reset")

endmodule

// ===== test/hsv_to_rgb_converter_tb.sv =====
`timescale 1ns / 1ps

module hsv_to_rgb_converter_tb;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

    // expected colours and the conversion that produces them
    class hsv_scoreboard;
        t_rgb        colour_q[$];
        int unsigned errors;

        function int unsigned round_half_up(int unsigned num, int unsigned den);
            return (2 * num + den) / (2 * den);
        endfunction

        function t_rgb convert(logic [7:0] hue, logic [7:0] sat, logic [7:0] bri);
            int unsigned s;
            int unsigned v;
            int unsigned scaled;
            int unsigned sector;
            int unsigned frac;
            int unsigned cv;
            int unsigned cp;
            int unsigned cq;
            int unsigned ct;
            t_rgb        res;
            s = (sat > hsv_pkg::PCT_MAX) ? hsv_pkg::PCT_MAX : int'(sat);
            v = (bri > hsv_pkg::PCT_MAX) ? hsv_pkg::PCT_MAX : int'(bri);
            cv = round_half_up(255 * v, 100);
            // grey when there is no saturation
            if (s == 0) begin
                res = '{cv[7:0], cv[7:0], cv[7:0]};
            end else begin
                scaled = 6 * hue;
                sector = scaled / 255;
                frac   = scaled % 255;
                cp = round_half_up(255 * v * (100 - s), 10000);
                cq = round_half_up(v * (25500 - s * frac), 10000);
                ct = round_half_up(v * (25500 - s * (255 - frac)), 10000);
                // hue 255 lands in sector six and shares the last case
                case (sector)
                    0: res = '{cv[7:0], ct[7:0], cp[7:0]};
                    1: res = '{cq[7:0], cv[7:0], cp[7:0]};
                    2: res = '{cp[7:0], cv[7:0], ct[7:0]};
                    3: res = '{cp[7:0], cq[7:0], cv[7:0]};
                    4: res = '{ct[7:0], cp[7:0], cv[7:0]};
                    default: res = '{cv[7:0], cp[7:0], cq[7:0]};
                endcase
            end
            return res;
        endfunction

        function void note_colour(logic [7:0] hue, logic [7:0] sat, logic [7:0] bri);
            colour_q.push_back(convert(hue, sat, bri));
        endfunction

        function void check_colour(logic [7:0] red, logic [7:0] green, logic [7:0] blue);
            t_rgb exp_c;
            if (colour_q.size() == 0) begin
                $display("%0t: unexpected beat r=%0d g=%0d b=%0d", $time, red, green, blue);
                errors++;
                return;
            end
            exp_c = colour_q.pop_front();
            if (red !== exp_c.red) begin
                $display("%0t: red expected %0d actual %0d", $time, exp_c.red, red);
                errors++;
            end
            if (green !== exp_c.green) begin
                $display("%0t: green expected %0d actual %0d", $time, exp_c.green, green);
                errors++;
            end
            if (blue !== exp_c.blue) begin
                $display("%0t: blue expected %0d actual %0d", $time, exp_c.blue, blue);
                errors++;
            end
        endfunction

        function int unsigned pending();
            return colour_q.size();
        endfunction
    endclass

    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned HOLD_CYCLES    = 80;
    localparam int unsigned RANDOM_BEATS   = 510;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_stall;
    logic [7:0] i_hue;
    logic [7:0] i_saturation;
    logic [7:0] i_brightness;
    logic       o_valid;
    logic       i_stall;
    logic [7:0] o_red;
    logic [7:0] o_green;
    logic [7:0] o_blue;

    hsv_scoreboard sb;
    int unsigned   tx_idle_pct;
    int unsigned   rx_idle_pct;
    int unsigned   hold_req_cnt;
    int unsigned   idle_cycles;

    hsv_to_rgb_converter dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_hue        (i_hue),
        .i_saturation (i_saturation),
        .i_brightness (i_brightness),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_red        (o_red),
        .o_green      (o_green),
        .o_blue       (o_blue)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // beats seen on both channels
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_stall) begin
            sb.note_colour(i_hue, i_saturation, i_brightness);
        end
        if (i_rst_n && o_valid && !i_stall) begin
            sb.check_colour(o_red, o_green, o_blue);
        end
    end

    // receiver back-pressure, with a long hold-off on request
    initial begin : receiver
        int unsigned hold_seen;
        int unsigned hold_left;
        hold_seen = 0;
        hold_left = 0;
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req_cnt != hold_seen) begin
                hold_seen = hold_req_cnt;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= ($urandom_range(99) < rx_idle_pct);
            end
        end
    end

    // watchdog on cycles without any beat
    initial begin
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("DONE: errors detected");
        $finish;
    end

    // offer one colour and wait until it is taken
    task automatic send_colour(input logic [7:0] hue, input logic [7:0] sat,
                               input logic [7:0] bri);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_hue        <= hue;
        i_saturation <= sat;
        i_brightness <= bri;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    // mostly in-range percentages, with zero and out-of-range bytes mixed in
    function automatic logic [7:0] rand_percent();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 10) return 8'd0;
        if (pick < 15) return 8'd100;
        if (pick < 35) return 8'($urandom_range(255));
        return 8'($urandom_range(100));
    endfunction

    task automatic send_random(input int unsigned count);
        for (int unsigned n = 0; n < count; n++) begin
            send_colour(8'($urandom_range(255)), rand_percent(), rand_percent());
        end
    endtask

    initial begin
        sb           = new;
        tx_idle_pct  = 0;
        rx_idle_pct  = 0;
        hold_req_cnt = 0;
        i_rst_n      <= 1'b0;
        i_valid      <= 1'b0;
        i_hue        <= 8'd0;
        i_saturation <= 8'd0;
        i_brightness <= 8'd0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // sector boundaries at full saturation and brightness
        send_colour(8'd0,   8'd100, 8'd100);
        send_colour(8'd42,  8'd100, 8'd100);
        send_colour(8'd43,  8'd100, 8'd100);
        send_colour(8'd85,  8'd100, 8'd100);
        send_colour(8'd127, 8'd100, 8'd100);
        send_colour(8'd128, 8'd100, 8'd100);
        send_colour(8'd170, 8'd100, 8'd100);
        send_colour(8'd212, 8'd100, 8'd100);
        send_colour(8'd213, 8'd100, 8'd100);
        send_colour(8'd254, 8'd100, 8'd100);
        // hue at the top of the range
        send_colour(8'd255, 8'd100, 8'd100);
        send_colour(8'd255, 8'd37,  8'd73);
        // grey levels
        send_colour(8'd90,  8'd0,   8'd100);
        send_colour(8'd200, 8'd0,   8'd0);
        send_colour(8'd17,  8'd0,   8'd1);
        send_colour(8'd255, 8'd0,   8'd255);
        // saturating percentages
        send_colour(8'd60,  8'd255, 8'd255);
        send_colour(8'd150, 8'd101, 8'd200);
        send_colour(8'd30,  8'd128, 8'd101);
        // small and mid values
        send_colour(8'd100, 8'd100, 8'd0);
        send_colour(8'd1,   8'd1,   8'd1);
        send_colour(8'd64,  8'd50,  8'd50);
        send_colour(8'd191, 8'd99,  8'd99);
        send_colour(8'd170, 8'd127, 8'd127);

        // sender idles lightly, receiver heavily
        tx_idle_pct = 24;
        rx_idle_pct = 54;
        send_random(RANDOM_BEATS);

        // and the other way round
        tx_idle_pct = 54;
        rx_idle_pct = 24;
        send_random(RANDOM_BEATS);

        // full rate, with a long hold-off so the pipeline backs up
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_req_cnt++;
        send_random(RANDOM_BEATS);
        i_valid <= 1'b0;

        // drain
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
